### rtl/hcr_pkg.sv
`timescale 1ns / 1ps
package hcr_pkg;
  localparam int MaxWidth = 2048;
  localparam int ColW = 11;
  localparam int RowW = 12;
  localparam int GradW = 11;
  localparam int ProdW = 22;
  localparam int SumW = 27;
  localparam int RespW = 49;
  localparam logic [1:0] CfgWidth = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgK = 2'd2;

  typedef struct packed {
    logic signed [ProdW-1:0] xx;
    logic signed [ProdW-1:0] yy;
    logic signed [ProdW-1:0] xy;
  } prod_t;

  function automatic prod_t make_prod(logic signed [GradW-1:0] gx,
                                      logic signed [GradW-1:0] gy);
    prod_t p;
    p.xx = gx * gx;
    p.yy = gy * gy;
    p.xy = gx * gy;
    return p;
  endfunction
endpackage

### rtl/harris_corner_response_unit.sv
`timescale 1ns / 1ps
// Harris corner response over a 3x3 window of gradient products, smoothed by
// the 1-2-1 x 1-2-1 kernel (weights sum to 16, unnormalized). Gradient pairs
// enter in raster order, one beat at a time: the line memories are read at
// the accept edge and written back in the next cycle. Each interior pixel
// (r, c) emits one beat of R = A*C - B*B - floor(k_q16*(A+C)^2/2^16),
// saturated to 49 bits, when pixel (r+1, c+1) arrives; border pixels emit
// nothing. A beat runs through an eight-stage pipeline (memory read, window
// shift, window sums, multipliers, k term and difference, delay, combine,
// saturate), and after the saturate stage its result enters the output register.
// The input stays closed while any stage holds work and while the output
// register is full, so a new beat is taken only once the previous one has
// left the pipeline and, for an interior pixel, once the receiver has taken
// its result.
module harris_corner_response_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // grad_x[10:0], grad_y[21:11], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // response[48:0], zero fill
  output logic        m_axis_tlast    // frame_done
);
  localparam int CW = hcr_pkg::ColW;
  localparam int RW = hcr_pkg::RowW;
  localparam int SW = hcr_pkg::SumW;

  logic [11:0] width_q, height_q;
  logic [14:0] k_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd640; height_q <= 12'd480; k_q <= 15'd2621;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hcr_pkg::CfgWidth:  width_q  <= cfg_data_i[11:0];
        hcr_pkg::CfgHeight: height_q <= cfg_data_i[11:0];
        hcr_pkg::CfgK:      k_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry: width clamped to 3..2048, height at least 3.
  logic [11:0] eff_w, eff_h;
  assign eff_w = (width_q < 12'd3) ? 12'd3 :
                 (width_q > 12'(hcr_pkg::MaxWidth)) ? 12'(hcr_pkg::MaxWidth) : width_q;
  assign eff_h = (height_q < 12'd3) ? 12'd3 : height_q;

  // Pipeline: stage valid bits. Keep at most one item in flight below stage 1
  // beyond the output register so no result is ever dropped.
  logic [7:0] vld_q;
  logic       out_full_q;
  logic       busy;
  assign busy = |vld_q;
  assign s_axis_tready = !busy && !out_full_q;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  logic signed [10:0] gx, gy;
  assign gx = s_axis_tdata[10:0];
  assign gy = s_axis_tdata[21:11];

  // Position counters.
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [11:0]   col_ext;
  logic          last_col, last_row, emit;
  assign col_ext  = {1'b0, col_q};
  assign last_col = (col_ext + 12'd1) >= eff_w;
  assign last_row = ({1'b0, row_q} + 13'd1) >= {1'b0, eff_h};
  assign emit     = (row_q >= RW'(2)) && (col_q >= CW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0;
    end else if (acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Line memories: read at the accept edge, write back in the next cycle.
  logic [2*hcr_pkg::GradW-1:0] upper_mem  [hcr_pkg::MaxWidth];
  logic [2*hcr_pkg::GradW-1:0] middle_mem [hcr_pkg::MaxWidth];
  logic [21:0] up_rd_q, mid_rd_q;
  logic [21:0] cur_q;
  logic [CW-1:0] wa_q;
  logic          emit_q, done_q;
  always_ff @(posedge clk_i) begin
    if (acc) begin
      up_rd_q  <= upper_mem[col_q];
      mid_rd_q <= middle_mem[col_q];
      cur_q    <= {gy, gx};
      wa_q     <= col_q;
      emit_q   <= emit;
      done_q   <= last_col && last_row;
    end
    if (vld_q[0]) begin
      upper_mem[wa_q]  <= mid_rd_q;
      middle_mem[wa_q] <= cur_q;
    end
  end

  // Product window, rows r-2, r-1, r; column 2 newest.
  hcr_pkg::prod_t win_q [3][3];
  hcr_pkg::prod_t p_up, p_mid, p_cur;
  assign p_up  = hcr_pkg::make_prod(up_rd_q[10:0],  up_rd_q[21:11]);
  assign p_mid = hcr_pkg::make_prod(mid_rd_q[10:0], mid_rd_q[21:11]);
  assign p_cur = hcr_pkg::make_prod(cur_q[10:0],    cur_q[21:11]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
    end else if (vld_q[0]) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= p_up;
      win_q[1][2] <= p_mid;
      win_q[2][2] <= p_cur;
    end
  end

  // Stage 2: weighted window sums.
  logic signed [SW-1:0] a_d, b_d, c_d, a_q, b_q, c_q;
  always_comb begin
    a_d = '0; b_d = '0; c_d = '0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        a_d = a_d + (SW'(win_q[r][c].xx) <<< ((r == 1 ? 1 : 0) + (c == 1 ? 1 : 0)));
        c_d = c_d + (SW'(win_q[r][c].yy) <<< ((r == 1 ? 1 : 0) + (c == 1 ? 1 : 0)));
        b_d = b_d + (SW'(win_q[r][c].xy) <<< ((r == 1 ? 1 : 0) + (c == 1 ? 1 : 0)));
      end
  end

  // Stage 3: products ac, bb and t^2 (t = a + c, unsigned, below 2^26).
  logic signed [2*SW-1:0] ac_q, bb_q;
  logic [2*SW-1:0] t2_q;
  logic [SW-1:0] t;
  assign t = a_q + c_q;
  // Stage 4: k term split into high and low partial products.
  logic [2*SW-1:0] khi_q;
  logic [31:0]     klo_q;
  logic signed [2*SW:0] det_q, det4_q;
  // Stage 6/7.
  logic signed [2*SW+1:0] rv_q;
  logic [hcr_pkg::RespW-1:0] resp_q;
  logic done_p [7];
  logic emit_p [7];

  localparam logic signed [2*SW+1:0] RMax = (2*SW+2)'(64'sd281474976710655);
  localparam logic signed [2*SW+1:0] RMin = -(2*SW+2)'(64'sd281474976710656);

  always_ff @(posedge clk_i) begin
    a_q  <= a_d; b_q <= b_d; c_q <= c_d;
    ac_q <= a_q * c_q;
    bb_q <= b_q * b_q;
    t2_q <= (2*SW)'(t) * (2*SW)'(t);
    det_q <= (2*SW+1)'(ac_q) - (2*SW+1)'(bb_q);
    khi_q <= (t2_q >> 16) * (2*SW)'(k_q);
    klo_q <= 32'(t2_q[15:0]) * 32'(k_q);
    det4_q <= det_q;
    rv_q <= (2*SW+2)'(det4_q) - (2*SW+2)'(khi_q) - (2*SW+2)'(klo_q >> 16);
    resp_q <= (rv_q > RMax) ? RMax[hcr_pkg::RespW-1:0] :
              (rv_q < RMin) ? RMin[hcr_pkg::RespW-1:0] : rv_q[hcr_pkg::RespW-1:0];
    emit_p[0] <= emit_q; done_p[0] <= done_q;
    for (int i = 1; i < 7; i++) begin
      emit_p[i] <= emit_p[i-1]; done_p[i] <= done_p[i-1];
    end
  end

  // vld_q[0]: memory data ready; [1] window updated; [2] sums; [3] products;
  // [4] k term and difference; [5] delay; [6] combined; [7] saturated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[6:0], acc};
  end

  logic [hcr_pkg::RespW-1:0] out_q;
  logic                      last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_full_q <= 1'b0;
    else if (vld_q[7] && emit_p[6]) out_full_q <= 1'b1;
    else if (m_axis_tready) out_full_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (vld_q[7] && emit_p[6]) begin
      out_q  <= resp_q;
      last_q <= done_p[6];
    end
  end

  assign m_axis_tvalid = out_full_q;
  assign m_axis_tdata  = {7'd0, out_q};
  assign m_axis_tlast  = last_q;
endmodule

### rtl/hcr_checker.sv
`timescale 1ns / 1ps
module hcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped while stalled");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
    else $error("fill bits not zero");
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output held");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while one is in flight");
endmodule

bind harris_corner_response_unit hcr_checker u_hcr_checker (.*);
